// ----- design/fixed_capacity_key_value_table_unit_defines.svh -----
// Assertion macros for the fixed-capacity key/value table unit.
// Included by the top level only; depends on nothing else.
`ifndef FIXED_CAPACITY_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define FIXED_CAPACITY_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCKVT_ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCKVT_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fckvt_pkg.sv -----
// Shared types and constants for the fixed-capacity key/value table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fckvt_pkg;

	// Port field widths
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 64;
	localparam int POS_W    = 6;
	localparam int CNT_W    = 7;
	localparam int MODE_W   = 3;
	localparam int S_DATA_W = 104;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 104;
	localparam int M_USER_W = 1;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UPDATE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UPSERT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ERASE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ_POS = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PREAD,
		ST_PDATA,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- design/fixed_capacity_key_value_table_unit.sv -----
// Fixed-capacity key/value table: keys and values in two registered-read RAMs, entries packed in order.
// Search modes scan the slots serially from slot 0 until a key hit or past the last entry;
// read by position reads one slot (none when out of range); erase then moves the entries
// above the hit down by one slot. Unused modes go straight to the result.
// One request at a time; the next one is taken from the cycle after the result loads, so the
// serial key scan sets the request rate. Reset (arst_n low, async) empties the table; RAM contents are not cleared.
// Depends on fckvt_pkg, fckvt_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_key_value_table_unit #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request stream
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// [31:0] lookup_key, [95:32] new_value, [101:96] position, [103:102] zero
	input  wire logic [fckvt_pkg::S_DATA_W-1:0] s_tdata,
	// [2:0] mode
	input  wire logic [fckvt_pkg::S_USER_W-1:0] s_tuser,
	// result stream
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [31:0] found_key, [95:32] found_value, [102:96] entry_count, [103] zero
	output      logic [fckvt_pkg::M_DATA_W-1:0] m_tdata,
	// [0] ok
	output      logic [fckvt_pkg::M_USER_W-1:0] m_tuser
);

	import fckvt_pkg::*;

	// Slot address and entry-count widths
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [MODE_W-1:0]     mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [POS_W-1:0]      pos_q;

	logic [CW-1:0]         fill_q;     // entries held, slots 0..fill_q-1
	logic [CW-1:0]         issue_q;    // next slot to read in scan / shift
	logic                  rd_vld_s1;  // RAM read data belongs to rd_addr_s1
	logic [AW-1:0]         rd_addr_s1;

	// result staged until the output register frees up
	logic                  pend_ok_q;
	logic [KEY_W-1:0]      pend_key_q;
	logic [VALUE_W-1:0]    pend_val_q;

	// output register
	logic                  out_vld_q;
	logic                  out_ok_q;
	logic [KEY_W-1:0]      out_key_q;
	logic [VALUE_W-1:0]    out_val_q;
	logic [CNT_W-1:0]      out_cnt_q;

	// ------------------------------------------------------------------
	// RAM ports
	// ------------------------------------------------------------------
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [AW-1:0]         ram_waddr;
	logic                  key_we;
	logic                  val_we;
	logic [KEY_BITS-1:0]   key_wdata;
	logic [VALUE_BITS-1:0] val_wdata;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;

	fckvt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (ram_waddr),
		.wdata (key_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (key_rd)
	);

	fckvt_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (ram_waddr),
		.wdata (val_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (val_rd)
	);

	// ------------------------------------------------------------------
	// Decode
	// ------------------------------------------------------------------
	logic          accept;
	logic          out_load;
	logic          issue_ok;   // another slot left to read
	logic          sweep_end;  // scan / shift has run past the last entry
	logic          hit;
	logic          full;
	logic          pos_ok;
	logic [CW-1:0] pos_idx;
	logic          do_insert;  // miss that becomes an insert

	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_DONE) && (!out_vld_q || m_tready);
	assign issue_ok  = issue_q < fill_q;
	assign sweep_end = !rd_vld_s1 && !issue_ok;
	assign hit       = (state_q == ST_SCAN) && rd_vld_s1 && (key_rd == key_q);
	assign full      = fill_q == CW'(CAPACITY);
	assign pos_ok    = 32'(pos_q) < 32'(fill_q);
	assign pos_idx   = fill_q - CW'(1) - CW'(pos_q);
	assign do_insert = (state_q == ST_SCAN) && sweep_end && !full &&
	                   (mode_q inside {MODE_INSERT, MODE_UPSERT});

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser inside {[MODE_INSERT:MODE_LOOKUP]}) begin
						state_d = ST_SCAN;
					end else if (s_tuser == MODE_READ_POS) begin
						state_d = ST_PREAD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = (mode_q == MODE_ERASE) ? ST_SHIFT : ST_DONE;
				end else if (sweep_end) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (sweep_end) begin
					state_d = ST_DONE;
				end
			end
			ST_PREAD: begin
				state_d = pos_ok ? ST_PDATA : ST_DONE;
			end
			ST_PDATA: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// RAM control and handshake outputs
	// ------------------------------------------------------------------
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		ram_re    = 1'b0;
		ram_raddr = issue_q[AW-1:0];
		ram_waddr = rd_addr_s1;
		key_we    = 1'b0;
		val_we    = 1'b0;
		key_wdata = key_q;
		val_wdata = val_q;
		case (state_q)
			ST_SCAN: begin
				ram_re = issue_ok;
				if (hit && (mode_q inside {MODE_UPDATE, MODE_UPSERT})) begin
					// overwrite value in place
					val_we = 1'b1;
				end else if (do_insert) begin
					// append at the end
					ram_waddr = fill_q[AW-1:0];
					key_we    = 1'b1;
					val_we    = 1'b1;
				end
			end
			ST_SHIFT: begin
				// read the next slot while writing the previous read, from slot j+1, into slot j
				ram_re = issue_ok;
				if (rd_vld_s1) begin
					ram_waddr = rd_addr_s1 - AW'(1);
					key_wdata = key_rd;
					val_wdata = val_rd;
					key_we    = 1'b1;
					val_we    = 1'b1;
				end
			end
			ST_PREAD: begin
				ram_re    = pos_ok;
				ram_raddr = pos_idx[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					issue_q   <= '0;
					rd_vld_s1 <= 1'b0;
				end
				ST_SCAN: begin
					if (hit && mode_q == MODE_ERASE) begin
						// start moving the entries above the hit down by one
						issue_q   <= CW'(rd_addr_s1) + CW'(1);
						rd_vld_s1 <= 1'b0;
					end else begin
						rd_vld_s1 <= issue_ok;
						if (issue_ok) begin
							issue_q <= issue_q + CW'(1);
						end
					end
					if (do_insert) begin
						fill_q <= fill_q + CW'(1);
					end
				end
				ST_SHIFT: begin
					rd_vld_s1 <= issue_ok;
					if (issue_ok) begin
						issue_q <= issue_q + CW'(1);
					end
					if (sweep_end) begin
						fill_q <= fill_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= s_tuser;
			key_q      <= KEY_BITS'(s_tdata[31:0]);
			val_q      <= VALUE_BITS'(s_tdata[95:32]);
			pos_q      <= s_tdata[101:96];
			pend_ok_q  <= 1'b0;
			pend_key_q <= '0;
			pend_val_q <= '0;
		end
		if (state_q == ST_SCAN || state_q == ST_SHIFT) begin
			rd_addr_s1 <= issue_q[AW-1:0];
		end
		if (hit) begin
			// insert of a present key fails; the others succeed
			pend_ok_q <= (mode_q != MODE_INSERT);
			if (mode_q == MODE_LOOKUP) begin
				pend_val_q <= VALUE_W'(val_rd);
			end
		end
		if (do_insert) begin
			pend_ok_q <= 1'b1;
		end
		if (state_q == ST_PDATA) begin
			pend_ok_q  <= 1'b1;
			pend_key_q <= KEY_W'(key_rd);
			pend_val_q <= VALUE_W'(val_rd);
		end
		if (out_load) begin
			out_ok_q  <= pend_ok_q;
			out_key_q <= pend_key_q;
			out_val_q <= pend_val_q;
			out_cnt_q <= CNT_W'(fill_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_val_q, out_key_q};
	assign m_tuser  = out_ok_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`include "fixed_capacity_key_value_table_unit_defines.svh"

	`FCKVT_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(CAPACITY),
		"fill count above capacity")
	`FCKVT_ASSERT_NEXT(a_idle_fill, clk, arst_n, state_q == ST_IDLE,
		fill_q == $past(fill_q), "fill count moved while idle")
	`FCKVT_ASSERT_IMPL(a_shift_addr, clk, arst_n, (state_q == ST_SHIFT) && rd_vld_s1,
		rd_addr_s1 != '0, "shift write below slot zero")
	`FCKVT_ASSERT_IMPL(a_write_state, clk, arst_n, key_we || val_we,
		(state_q == ST_SCAN) || (state_q == ST_SHIFT), "RAM write outside scan or shift")

endmodule

`default_nettype wire

// ----- design/fckvt_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fckvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output      logic [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
